@@ design/vmrq_pkg.sv @@
`timescale 1ns / 1ps

package vmrq_pkg;

	localparam logic [1:0] CMD_ALLOC    = 2'd0;
	localparam logic [1:0] CMD_COMPLETE = 2'd1;
	localparam logic [1:0] CMD_PEEK     = 2'd2;
	localparam logic [1:0] CMD_FREE     = 2'd3;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_NO_ROOM    = 2'd1;
	localparam logic [1:0] ST_EMPTY      = 2'd2;
	localparam logic [1:0] ST_INCOMPLETE = 2'd3;

	localparam logic [14:0] QUEUE_BYTES_RESET = 15'd16384;
	localparam int HDR_W = 16;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [14:0] length;
		logic [14:0] msg_offset;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [14:0] payload_offset;
		logic [14:0] msg_length;
		logic [14:0] byte_count;
	} result_t;

endpackage

@@ design/vmrq_hdr_ram.sv @@
`timescale 1ns / 1ps

module vmrq_hdr_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/variable_message_ring_queue.sv @@
`timescale 1ns / 1ps
// done is high in the cycle after the busy cycle
// a new command is not accepted while busy; the header ram read is followed by the update
// busy is high for the single cycle between accept and the result beat
// the receiver cannot stall; each result beat is shown for exactly one cycle
// asynchronous reset clears pointers, count and control; ring size returns to 16384 bytes

module variable_message_ring_queue #(
	parameter int BUF_BYTES = 16384
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  vmrq_pkg::item_t  item,
	output logic             done,
	output vmrq_pkg::result_t result,
	input  logic             queue_bytes_we,
	input  logic [14:0]      queue_bytes
);

	import vmrq_pkg::*;

	localparam int HDR_DEPTH = BUF_BYTES / 4;
	localparam int AW = $clog2(HDR_DEPTH);
	localparam logic [16:0] BUF_W = 17'(BUF_BYTES);
	localparam logic [16:0] DEPTH_W = 17'(HDR_DEPTH);

	typedef enum logic {IDLE, EXEC} state_t;

	state_t state_q;
	logic [14:0] queue_bytes_q;
	logic [14:0] head_q, tail_q, wrap_q, count_q;
	item_t item_q;
	logic rd_ok_q, cmpl_ok_q;
	logic [AW-1:0] cmpl_idx_q;

	logic accept;
	logic [14:0] cmpl_pos, rd_pos;
	logic [16:0] rd_pos17, cmpl_pos17;
	logic [AW-1:0] rd_idx;
	logic [HDR_W-1:0] rd_data, hdr;

	logic [14:0] size;
	logic [16:0] need, tail_need, free_need, head_next;
	logic alloc_ok, do_wrap, empty;
	logic [14:0] base;
	logic [16:0] base17;
	logic [14:0] free_len;

	logic [14:0] head_d, tail_d, wrap_d, count_d;
	result_t res_d;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic [HDR_W-1:0] mem_wdata;

	assign busy = (state_q == EXEC);
	assign accept = start && !busy;

	assign cmpl_pos = item.msg_offset - 15'd4;
	assign rd_pos = (item.cmd == CMD_COMPLETE) ? cmpl_pos : head_q;
	assign rd_pos17 = {2'b00, rd_pos};
	assign cmpl_pos17 = {2'b00, cmpl_pos};
	assign rd_idx = rd_pos17[AW+1:2];

	vmrq_hdr_ram #(
		.DEPTH(HDR_DEPTH),
		.AW(AW),
		.DW(HDR_W)
	) u_hdr_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(accept),
		.raddr(rd_idx),
		.rdata(rd_data)
	);

	always_comb begin
		hdr = rd_ok_q ? rd_data : '0;
		size = ({2'b00, queue_bytes_q} > BUF_W) ? BUF_W[14:0] : queue_bytes_q;
		need = ({2'b00, item_q.length} + 17'd7) & ~17'd3;
		tail_need = {2'b00, tail_q} + need;
		empty = (head_q == tail_q) && (wrap_q == '0);
		alloc_ok = 1'b0;
		do_wrap = 1'b0;
		if (tail_q == head_q) begin
			alloc_ok = (wrap_q == '0) && (need <= {2'b00, size});
		end else if (tail_q > head_q) begin
			if (tail_need <= {2'b00, size}) begin
				alloc_ok = 1'b1;
			end else if (need > {2'b00, head_q}) begin
				alloc_ok = 1'b0;
			end else begin
				alloc_ok = 1'b1;
				do_wrap = 1'b1;
			end
		end else begin
			alloc_ok = tail_need <= {2'b00, head_q};
		end
		base = do_wrap ? 15'd0 : tail_q;
		base17 = {2'b00, base};
		free_len = hdr[14:0];
		free_need = ({2'b00, free_len} + 17'd7) & ~17'd3;
		head_next = {2'b00, head_q} + free_need;
	end

	always_comb begin
		res_d = '0;
		res_d.status = ST_OK;
		head_d = head_q;
		tail_d = tail_q;
		wrap_d = wrap_q;
		count_d = count_q;
		case (item_q.cmd)
			CMD_ALLOC: begin
				if (alloc_ok) begin
					if (do_wrap) begin
						wrap_d = tail_q;
					end
					tail_d = 15'(base17 + need);
					count_d = count_q + item_q.length;
					res_d.payload_offset = base + 15'd4;
				end else begin
					res_d.status = ST_NO_ROOM;
				end
			end
			CMD_COMPLETE: begin
				res_d.status = ST_OK;
			end
			CMD_PEEK: begin
				if (empty) begin
					res_d.status = ST_EMPTY;
				end else if (hdr[15]) begin
					res_d.status = ST_INCOMPLETE;
				end else begin
					res_d.payload_offset = head_q + 15'd4;
					res_d.msg_length = hdr[14:0];
				end
			end
			default: begin
				if (empty) begin
					res_d.status = ST_EMPTY;
				end else begin
					count_d = (free_len > count_q) ? '0 : count_q - free_len;
					if (wrap_q != '0) begin
						if (head_next >= {2'b00, wrap_q}) begin
							head_d = '0;
							wrap_d = '0;
						end else begin
							head_d = head_next[14:0];
						end
					end else if (head_next >= {2'b00, tail_q}) begin
						head_d = '0;
						tail_d = '0;
					end else begin
						head_d = head_next[14:0];
					end
				end
			end
		endcase
		res_d.byte_count = count_d;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = cmpl_idx_q;
		mem_wdata = {1'b0, hdr[14:0]};
		if (busy) begin
			case (item_q.cmd)
				CMD_ALLOC: begin
					mem_we = alloc_ok;
					mem_waddr = base17[AW+1:2];
					mem_wdata = {1'b1, item_q.length};
				end
				CMD_COMPLETE: begin
					mem_we = cmpl_ok_q;
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done <= 1'b0;
			result <= '0;
			item_q <= '0;
			rd_ok_q <= 1'b0;
			cmpl_ok_q <= 1'b0;
			cmpl_idx_q <= '0;
			queue_bytes_q <= QUEUE_BYTES_RESET;
			head_q <= '0;
			tail_q <= '0;
			wrap_q <= '0;
			count_q <= '0;
		end else begin
			done <= busy;
			case (state_q)
				IDLE: begin
					if (start) begin
						state_q <= EXEC;
						item_q <= item;
						rd_ok_q <= (rd_pos17 >> 2) < DEPTH_W;
						cmpl_ok_q <= (item.msg_offset >= 15'd4) && ((cmpl_pos17 >> 2) < DEPTH_W);
						cmpl_idx_q <= cmpl_pos17[AW+1:2];
					end
				end
				EXEC: begin
					state_q <= IDLE;
					result <= res_d;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
			if (queue_bytes_we) begin
				queue_bytes_q <= queue_bytes;
				head_q <= '0;
				tail_q <= '0;
				wrap_q <= '0;
				count_q <= '0;
			end else if (busy) begin
				head_q <= head_d;
				tail_q <= tail_d;
				wrap_q <= wrap_d;
				count_q <= count_d;
			end
		end
	end

endmodule

@@ design/vmrq_checker.sv @@
`timescale 1ns / 1ps

module vmrq_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input vmrq_pkg::result_t result
);

	import vmrq_pkg::*;

	// every accepted beat is followed by one busy cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after accept");

	a_result_two_after: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("result beat missing two cycles after accept");

	a_busy_single: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy && done)
		else $error("busy longer than one cycle or no result");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result beat without preceding work");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != ST_OK |-> result.payload_offset == '0 && result.msg_length == '0)
		else $error("nonzero fields on failed command");

endmodule

bind variable_message_ring_queue vmrq_checker u_vmrq_checker (.*);
